// ===== design/boxds_pkg.sv =====
// Shared types and constants of the 2x2 box downscaler.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package boxds_pkg;

   // Default size of the line store, in output columns
   localparam int MAX_OUT_WIDTH = 512;

   // Field widths
   localparam int PIXEL_W    = 16;
   localparam int GRAY_W     = 8;
   localparam int COUNT_W    = 11;
   localparam int OUT_DIM_W  = 10;
   localparam int ROW_LEN_W  = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // Line store entry: pair sum in the low bits, pixel count above it (nonzero pixels in depth mode)
   localparam int SUM_W   = 17;
   localparam int CNT_W   = 2;
   localparam int ENTRY_W = SUM_W + CNT_W;

   // Block totals
   localparam int TSUM_W = SUM_W + 1;
   localparam int TCNT_W = CNT_W + 1;

   // Divide by three: floor(x / 3) == (x * RECIP3) >> DIV3_SHIFT for x < 2**19
   localparam int                 RECIP3_W   = 19;
   localparam logic [RECIP3_W-1:0] RECIP3    = 19'd349526;
   localparam int                 DIV3_SHIFT = 20;
   localparam int                 PROD_W     = TSUM_W + RECIP3_W;

   // Register reset values
   localparam logic                  DEPTH_MODE_RST = 1'b0;
   localparam logic [OUT_DIM_W-1:0]  OUT_WIDTH_RST  = 10'd320;
   localparam logic [OUT_DIM_W-1:0]  OUT_HEIGHT_RST = 10'd240;
   localparam logic [ROW_LEN_W-1:0]  ROW_LENGTH_RST = 12'd640;

   // Count limit: columns wrap and rows saturate here
   localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEPTH_MODE = 2'd0,
      CSR_OUT_WIDTH  = 2'd1,
      CSR_OUT_HEIGHT = 2'd2,
      CSR_ROW_LENGTH = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SUM  = 2'd1,
      ST_MUL  = 2'd2,
      ST_FIN  = 2'd3
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;    // input beat taken this cycle
      logic sum_load;  // combine stored upper pair with lower pair
      logic mul_load;  // register reciprocal product
      logic out_load;  // load result into output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic produce;   // beat in hand completes a 2x2 block
      logic out_free;  // output register empty or emptying this cycle
   } status_type;

endpackage

`default_nettype wire

// ===== design/boxds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the line store of partial pair sums.
`timescale 1ns / 1ps
`default_nettype none

module boxds_ram #(
   parameter int WIDTH = 19,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/boxds_ctrl.sv =====
// Controller of the 2x2 box downscaler: sequences one block result through
// store read, sum, reciprocal multiply and output load. Uses boxds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module boxds_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire boxds_pkg::status_type  status,
   output boxds_pkg::cmd_type          cmd
);

   boxds_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= boxds_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         boxds_pkg::ST_IDLE: begin
            if (req_valid && status.produce) begin
               state_in = boxds_pkg::ST_SUM;
            end
         end
         boxds_pkg::ST_SUM: state_in = boxds_pkg::ST_MUL;
         boxds_pkg::ST_MUL: state_in = boxds_pkg::ST_FIN;
         boxds_pkg::ST_FIN: begin
            // hold until the output register can take the result
            if (status.out_free) begin
               state_in = boxds_pkg::ST_IDLE;
            end
         end
         default: state_in = boxds_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall    = 1'b1;
      cmd.accept   = 1'b0;
      cmd.sum_load = 1'b0;
      cmd.mul_load = 1'b0;
      cmd.out_load = 1'b0;
      case (state_ff)
         boxds_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         boxds_pkg::ST_SUM: cmd.sum_load = 1'b1;
         boxds_pkg::ST_MUL: cmd.mul_load = 1'b1;
         boxds_pkg::ST_FIN: cmd.out_load = status.out_free;
         default: req_stall = 1'b1;
      endcase
   end

endmodule

`default_nettype wire

// ===== design/boxds_datapath.sv =====
// Datapath of the 2x2 box downscaler: configuration registers, raster counts,
// pair sums, line store, block average and output register. Uses boxds_pkg, boxds_ram.
`timescale 1ns / 1ps
`default_nettype none

module boxds_datapath #(
   parameter int MAX_OUT_WIDTH = boxds_pkg::MAX_OUT_WIDTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [boxds_pkg::PIXEL_W-1:0]       req_pixel,
   input  wire logic                                req_frame_start,
   input  wire logic                                csr_valid,
   input  wire logic [boxds_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [boxds_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [boxds_pkg::PIXEL_W-1:0]       rsp_average,
   output logic                                     rsp_row_end,
   output logic                                     rsp_frame_end,
   input  wire boxds_pkg::cmd_type                  cmd,
   output boxds_pkg::status_type                    status
);

   localparam int AW   = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
   localparam int OC_W = boxds_pkg::COUNT_W - 1;
   localparam int XW   = (AW > OC_W) ? AW : OC_W;

   // Configuration
   logic                               depth_mode_ff, depth_mode_in;
   logic [boxds_pkg::OUT_DIM_W-1:0]    out_width_ff, out_width_in;
   logic [boxds_pkg::OUT_DIM_W-1:0]    out_height_ff, out_height_in;
   logic [boxds_pkg::ROW_LEN_W-1:0]    row_length_ff, row_length_in;

   // Raster position and left pixel
   logic [boxds_pkg::COUNT_W-1:0]      col_ff, col_in;
   logic [boxds_pkg::COUNT_W-1:0]      row_ff, row_in;
   logic [boxds_pkg::PIXEL_W-1:0]      left_ff, left_in;

   // Block pipeline
   logic [boxds_pkg::SUM_W-1:0]        pair_sum_ff, pair_sum_in;
   logic [boxds_pkg::CNT_W-1:0]        pair_cnt_ff, pair_cnt_in;
   logic                               row_end_ff, row_end_in;
   logic                               frame_end_ff, frame_end_in;
   logic [boxds_pkg::TSUM_W-1:0]       tsum_ff, tsum_in;
   logic [boxds_pkg::TCNT_W-1:0]       tcnt_ff, tcnt_in;
   logic [boxds_pkg::PROD_W-1:0]       prod_ff, prod_in;

   // Output register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [boxds_pkg::PIXEL_W-1:0]      average_ff, average_in;
   logic                               out_row_end_ff, out_row_end_in;
   logic                               out_frame_end_ff, out_frame_end_in;

   // Combinational
   logic [boxds_pkg::COUNT_W-1:0]      c, r;
   logic [OC_W-1:0]                    ocol, orow;
   logic [XW-1:0]                      ocol_x;
   logic                               in_area, odd_col, odd_row, wrap;
   logic [boxds_pkg::SUM_W-1:0]        sum_now;
   logic [boxds_pkg::CNT_W-1:0]        cnt_now;
   logic                               last_col;
   logic [AW-1:0]                      store_addr;
   logic                               store_wr;
   logic [boxds_pkg::ENTRY_W-1:0]      store_rd;
   logic [boxds_pkg::TSUM_W-1:0]       avg_wide;

   always_comb begin
      c        = req_frame_start ? '0 : col_ff;
      r        = req_frame_start ? '0 : row_ff;
      ocol     = c[boxds_pkg::COUNT_W-1:1];
      orow     = r[boxds_pkg::COUNT_W-1:1];
      ocol_x   = XW'(ocol);
      odd_col  = c[0];
      odd_row  = r[0];
      in_area  = (ocol < out_width_ff) && (orow < out_height_ff)
                 && (32'(ocol) < 32'(MAX_OUT_WIDTH));
      wrap     = ((12'(c) + 12'd1) >= row_length_ff) || (c == boxds_pkg::COUNT_MAX);
      last_col = (11'(ocol) + 11'd1) == 11'(out_width_ff);

      if (depth_mode_ff) begin
         sum_now = 17'(left_ff) + 17'(req_pixel);
         cnt_now = 2'(left_ff != '0) + 2'(req_pixel != '0);
      end else begin
         sum_now = 17'(left_ff[boxds_pkg::GRAY_W-1:0])
                 + 17'(req_pixel[boxds_pkg::GRAY_W-1:0]);
         cnt_now = 2'd2;
      end

      store_addr     = ocol_x[AW-1:0];
      store_wr       = cmd.accept && in_area && odd_col && !odd_row;
      status.produce = in_area && odd_col && odd_row;
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   // Configuration writes
   always_comb begin
      depth_mode_in = depth_mode_ff;
      out_width_in  = out_width_ff;
      out_height_in = out_height_ff;
      row_length_in = row_length_ff;
      if (csr_valid) begin
         case (csr_index)
            boxds_pkg::CSR_DEPTH_MODE: depth_mode_in = csr_data[0];
            boxds_pkg::CSR_OUT_WIDTH:  out_width_in  = csr_data[boxds_pkg::OUT_DIM_W-1:0];
            boxds_pkg::CSR_OUT_HEIGHT: out_height_in = csr_data[boxds_pkg::OUT_DIM_W-1:0];
            boxds_pkg::CSR_ROW_LENGTH: row_length_in = csr_data;
            default: ;
         endcase
      end
   end

   // Raster counts, held left pixel, pair sum and count, and end flags
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      left_in     = left_ff;
      pair_sum_in = pair_sum_ff;
      pair_cnt_in = pair_cnt_ff;
      row_end_in  = row_end_ff;
      frame_end_in = frame_end_ff;
      if (cmd.accept) begin
         if (wrap) begin
            col_in = '0;
            row_in = (r == boxds_pkg::COUNT_MAX) ? r : r + 11'd1;
         end else begin
            col_in = c + 11'd1;
            row_in = r;
         end
         if (in_area && !odd_col) begin
            left_in = req_pixel;
         end
         pair_sum_in  = sum_now;
         pair_cnt_in  = cnt_now;
         row_end_in   = last_col;
         frame_end_in = last_col && ((11'(orow) + 11'd1) == 11'(out_height_ff));
      end
   end

   // Block total, reciprocal product and result
   always_comb begin
      tsum_in = tsum_ff;
      tcnt_in = tcnt_ff;
      if (cmd.sum_load) begin
         tsum_in = 18'(pair_sum_ff) + 18'(store_rd[boxds_pkg::SUM_W-1:0]);
         tcnt_in = 3'(pair_cnt_ff) + 3'(store_rd[boxds_pkg::ENTRY_W-1:boxds_pkg::SUM_W]);
      end
      prod_in = cmd.mul_load ? (37'(tsum_ff) * 37'(boxds_pkg::RECIP3)) : prod_ff;

      if (depth_mode_ff) begin
         case (tcnt_ff)
            3'd0:    avg_wide = '0;
            3'd1:    avg_wide = tsum_ff;
            3'd2:    avg_wide = tsum_ff >> 1;
            3'd3:    avg_wide = 18'(prod_ff[boxds_pkg::PROD_W-1:boxds_pkg::DIV3_SHIFT]);
            3'd4:    avg_wide = tsum_ff >> 2;
            default: avg_wide = '0;
         endcase
      end else begin
         avg_wide = tsum_ff >> 2;
      end

      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      average_in        = average_ff;
      out_row_end_in    = out_row_end_ff;
      out_frame_end_in  = out_frame_end_ff;
      if (cmd.out_load) begin
         rsp_valid_in     = 1'b1;
         // saturate the depth mean of a block
         average_in       = (|avg_wide[boxds_pkg::TSUM_W-1:boxds_pkg::PIXEL_W])
                            ? '1 : avg_wide[boxds_pkg::PIXEL_W-1:0];
         out_row_end_in   = row_end_ff;
         out_frame_end_in = frame_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_mode_ff <= boxds_pkg::DEPTH_MODE_RST;
         out_width_ff  <= boxds_pkg::OUT_WIDTH_RST;
         out_height_ff <= boxds_pkg::OUT_HEIGHT_RST;
         row_length_ff <= boxds_pkg::ROW_LENGTH_RST;
         col_ff        <= '0;
         row_ff        <= '0;
         left_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         depth_mode_ff <= depth_mode_in;
         out_width_ff  <= out_width_in;
         out_height_ff <= out_height_in;
         row_length_ff <= row_length_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         left_ff       <= left_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pair_sum_ff      <= pair_sum_in;
      pair_cnt_ff      <= pair_cnt_in;
      row_end_ff       <= row_end_in;
      frame_end_ff     <= frame_end_in;
      tsum_ff          <= tsum_in;
      tcnt_ff          <= tcnt_in;
      prod_ff          <= prod_in;
      average_ff       <= average_in;
      out_row_end_ff   <= out_row_end_in;
      out_frame_end_ff <= out_frame_end_in;
   end

   boxds_ram #(
      .WIDTH (boxds_pkg::ENTRY_W),
      .DEPTH (MAX_OUT_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (store_addr),
      .wr_data ({cnt_now, sum_now}),
      .rd_en   (cmd.accept),
      .rd_addr (store_addr),
      .rd_data (store_rd)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_average   = average_ff;
   assign rsp_row_end   = out_row_end_ff;
   assign rsp_frame_end = out_frame_end_ff;

endmodule

`default_nettype wire

// ===== design/box_downscale_2x2_top.sv =====
// Top level of the 2x2 box downscaler: controller, datapath and CSR port.
// Uses boxds_pkg, boxds_ctrl, boxds_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Raster pixels in, one averaged pixel out per 2x2 block of the used area
// (gray: mean of the low bytes; depth: mean of the nonzero 16-bit pixels).
// A pixel that does not finish a block needs no further step, so such beats
// stream at one per clock while no block is in work. For the lower-right pixel,
// its accepting edge also reads the line store, then come the block sum, the
// reciprocal multiply for the divide by three and the output register load,
// with the input stalled through the SUM, MUL and FIN states; that load waits
// further while the previous result is still held by rsp_stall. The output
// register lets the next input beat in while a result waits. The line store
// holds one entry per output column (MAX_OUT_WIDTH) and needs no clearing;
// write the CSRs only while the block is idle. csr_ready is always high.
module box_downscale_2x2_top #(
   parameter int MAX_OUT_WIDTH = boxds_pkg::MAX_OUT_WIDTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [boxds_pkg::PIXEL_W-1:0]     req_pixel,
   input  wire logic                              req_frame_start,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [boxds_pkg::PIXEL_W-1:0]     rsp_average,
   output logic                                   rsp_row_end,
   output logic                                   rsp_frame_end,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [boxds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [boxds_pkg::CSR_DATA_W-1:0]  csr_data
);

   boxds_pkg::cmd_type    cmd;
   boxds_pkg::status_type status;

   assign csr_ready = 1'b1;

   boxds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   boxds_datapath #(
      .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .csr_valid       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_average     (rsp_average),
      .rsp_row_end     (rsp_row_end),
      .rsp_frame_end   (rsp_frame_end),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

`default_nettype wire
